FILE: rtl/rcef_pkg.sv
// shared types and constants for the raster corner extreme finder
`timescale 1ns / 1ps
`default_nettype none

package rcef_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_W        = 13;
  localparam int COORD_W      = 12;
  localparam int N_CORNER     = 4;
  localparam int S_TDATA_W    = 8;
  localparam int OUT_BITS     = 2 * N_CORNER * COORD_W + 1;
  localparam int M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int MAX_DIM_DFLT = 4096;

  localparam logic [PIX_W-1:0] BG_PIXEL         = 8'hff;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // corner slots, also the order in the result item
  typedef enum logic [1:0] {
    SLOT_TL = 2'd0,
    SLOT_BL = 2'd1,
    SLOT_BR = 2'd2,
    SLOT_TR = 2'd3
  } slot_e;

  typedef struct packed {
    logic advance;
    logic frame_end;
  } rcef_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rcef_raster_cnt.sv
// column and row counters with clamped frame bounds
`timescale 1ns / 1ps
`default_nettype none

module rcef_raster_cnt
  import rcef_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIM_DFLT,
  parameter int CW            = $clog2(MAX_DIMENSION)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CFG_W-1:0] frame_width_i,
  input  wire logic [CFG_W-1:0] frame_height_i,
  input  wire logic             advance_i,
  output logic      [CW-1:0]    col_o,
  output logic      [CW-1:0]    row_o,
  output logic                  frame_end_o
);

  localparam int DW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIMENSION);

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [DW-1:0] width_raw, height_raw;
  logic [DW-1:0] width_c, height_c;
  logic          col_last, row_last;

  assign width_raw  = DW'(frame_width_i);
  assign height_raw = DW'(frame_height_i);

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    priority if (width_raw == '0) begin
      width_c = DW'(1);
    end else if (width_raw > DIM_MAX) begin
      width_c = DIM_MAX;
    end else begin
      width_c = width_raw;
    end
    priority if (height_raw == '0) begin
      height_c = DW'(1);
    end else if (height_raw > DIM_MAX) begin
      height_c = DIM_MAX;
    end else begin
      height_c = height_raw;
    end
  end

  // at or past the bound wraps, also after a size change mid frame
  assign col_last    = (DW'(col_q) + DW'(1)) >= width_c;
  assign row_last    = (DW'(row_q) + DW'(1)) >= height_c;
  assign frame_end_o = col_last && row_last;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

`default_nettype wire

FILE: rtl/rcef_tracker.sv
// running sum and difference extremes and the four corner coordinates
`timescale 1ns / 1ps
`default_nettype none

module rcef_tracker
  import rcef_pkg::*;
#(
  parameter int CW = $clog2(MAX_DIM_DFLT)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rcef_ctrl_t                   ctrl_i,
  input  wire logic [PIX_W-1:0]             pixel_i,
  input  wire logic [CW-1:0]                col_i,
  input  wire logic [CW-1:0]                row_i,
  output logic      [N_CORNER-1:0][CW-1:0]  corner_x_o,
  output logic      [N_CORNER-1:0][CW-1:0]  corner_y_o,
  output logic                              seen_o
);

  localparam int SW = CW + 1;

  logic                        seen_q, seen_d;
  logic        [SW-1:0]        lsum_q, lsum_d;
  logic        [SW-1:0]        gsum_q, gsum_d;
  logic signed [SW-1:0]        ldiff_q, ldiff_d;
  logic signed [SW-1:0]        gdiff_q, gdiff_d;
  logic [N_CORNER-1:0][CW-1:0] cx_q, cx_d;
  logic [N_CORNER-1:0][CW-1:0] cy_q, cy_d;
  logic        [SW-1:0]        sum;
  logic signed [SW-1:0]        diff;
  logic                        fg;
  logic                        first;

  assign sum   = SW'(col_i) + SW'(row_i);
  assign diff  = $signed(SW'(col_i)) - $signed(SW'(row_i));
  assign fg    = ctrl_i.advance && (pixel_i != BG_PIXEL);
  assign first = !seen_q;

  // first foreground pixel of a frame loads every extreme
  always_comb begin
    seen_d  = seen_q;
    lsum_d  = lsum_q;
    gsum_d  = gsum_q;
    ldiff_d = ldiff_q;
    gdiff_d = gdiff_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    if (fg) begin
      seen_d = 1'b1;
      if (first || sum < lsum_q) begin
        lsum_d        = sum;
        cx_d[SLOT_TL] = col_i;
        cy_d[SLOT_TL] = row_i;
      end
      // last one wins ties on the bottom-right corner
      if (first || sum >= gsum_q) begin
        gsum_d        = sum;
        cx_d[SLOT_BR] = col_i;
        cy_d[SLOT_BR] = row_i;
      end
      if (first || diff < ldiff_q) begin
        ldiff_d       = diff;
        cx_d[SLOT_BL] = col_i;
        cy_d[SLOT_BL] = row_i;
      end
      if (first || diff > gdiff_q) begin
        gdiff_d       = diff;
        cx_d[SLOT_TR] = col_i;
        cy_d[SLOT_TR] = row_i;
      end
    end
  end

  assign corner_x_o = cx_d;
  assign corner_y_o = cy_d;
  assign seen_o     = seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      lsum_q  <= '0;
      gsum_q  <= '0;
      ldiff_q <= '0;
      gdiff_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
    end else if (ctrl_i.advance && ctrl_i.frame_end) begin
      seen_q  <= 1'b0;
      lsum_q  <= '0;
      gsum_q  <= '0;
      ldiff_q <= '0;
      gdiff_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
    end else begin
      seen_q  <= seen_d;
      lsum_q  <= lsum_d;
      gsum_q  <= gsum_d;
      ldiff_q <= ldiff_d;
      gdiff_q <= gdiff_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rcef_result_reg.sv
// result register holding one frame's corners until the sink takes it
`timescale 1ns / 1ps
`default_nettype none

module rcef_result_reg
  import rcef_pkg::*;
#(
  parameter int CW = $clog2(MAX_DIM_DFLT)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [N_CORNER-1:0][CW-1:0] corner_x_i,
  input  wire logic [N_CORNER-1:0][CW-1:0] corner_y_i,
  input  wire logic                        seen_i,
  input  wire logic                        ready_i,
  output logic                             valid_o,
  output logic      [M_TDATA_W-1:0]        data_o
);

  localparam int XW = (CW > COORD_W) ? CW : COORD_W;

  logic                 valid_q, valid_d;
  logic [M_TDATA_W-1:0] data_q, data_d;
  logic [N_CORNER-1:0][XW-1:0] ext_x, ext_y;

  for (genvar g = 0; g < N_CORNER; g++) begin : g_ext
    assign ext_x[g] = XW'(corner_x_i[g]);
    assign ext_y[g] = XW'(corner_y_i[g]);
  end

  always_comb begin
    data_d = '0;
    for (int i = 0; i < N_CORNER; i++) begin
      data_d[2*i*COORD_W +: COORD_W]     = ext_x[i][COORD_W-1:0];
      data_d[(2*i+1)*COORD_W +: COORD_W] = ext_y[i][COORD_W-1:0];
    end
    data_d[2*N_CORNER*COORD_W] = seen_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/raster_corner_extreme_finder_unit.sv
// top level of the raster corner extreme finder
//
//  port group   dir  contents
//  cfg_*        in   write enable, register index, 13-bit value (0 width, 1 height)
//  s_axis_*     in   one gray pixel per item, raster order
//  m_axis_*     out  four corners and a found flag, one item per frame
//
// one pixel per cycle unless stalled; corners update at the accepting edge, from live counters
// the result item is registered and shows in the cycle after the frame's last pixel is accepted
// pixels keep flowing while a result waits; only the last pixel of the next frame
// stalls until the output register is free
// reset sets width 640, height 480 and clears counters and extremes
`timescale 1ns / 1ps
`default_nettype none

module raster_corner_extreme_finder_unit
  import rcef_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIM_DFLT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // pixel_value
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // top_left_x, top_left_y, bottom_left_x, bottom_left_y, bottom_right_x,
  // bottom_right_y, top_right_x, top_right_y, any_found, zero pad
  output logic      [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(MAX_DIMENSION);

  logic [CFG_W-1:0]            frame_width_q, frame_height_q;
  logic [CW-1:0]               col, row;
  logic                        frame_end;
  logic                        accept;
  rcef_ctrl_t                  ctrl;
  logic [N_CORNER-1:0][CW-1:0] corner_x, corner_y;
  logic                        seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
      endcase
    end
  end

  // only an item that ends a frame needs room in the result register
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !frame_end;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ctrl          = rcef_ctrl_t'{advance: accept, frame_end: frame_end};

  rcef_raster_cnt #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .CW            (CW)
  ) u_cnt (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .advance_i      (accept),
    .col_o          (col),
    .row_o          (row),
    .frame_end_o    (frame_end)
  );

  rcef_tracker #(
    .CW (CW)
  ) u_trk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .pixel_i    (s_axis_tdata),
    .col_i      (col),
    .row_i      (row),
    .corner_x_o (corner_x),
    .corner_y_o (corner_y),
    .seen_o     (seen)
  );

  rcef_result_reg #(
    .CW (CW)
  ) u_res (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && frame_end),
    .corner_x_i (corner_x),
    .corner_y_i (corner_y),
    .seen_i     (seen),
    .ready_i    (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .data_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/rcef_checker.sv
// port-level checks for the raster corner extreme finder
`timescale 1ns / 1ps
`default_nettype none

module rcef_checker
  import rcef_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int FOUND_BIT = 2 * N_CORNER * COORD_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // empty frame reports all corners zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[FOUND_BIT] |-> m_axis_tdata[FOUND_BIT-1:0] == '0)
    else $error("corners nonzero with no foreground");

  // a new result only follows an accepted pixel
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without accepted item");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind raster_corner_extreme_finder_unit rcef_checker u_rcef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
